@@ sv/generational_handle_table_defines.svh @@
// Assertion macros shared by the handle table RTL.
`ifndef GENERATIONAL_HANDLE_TABLE_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define GHT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define GHT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define GHT_ASSERT(lbl, prop, msg)
`define GHT_NEVER(lbl, cond, msg)
`endif

`endif

@@ sv/ght_pkg.sv @@
`default_nettype none
package ght_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int GEN_BITS    = 16;
	localparam int REF_BITS    = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int FUNC_W      = 3;
	localparam int LIMIT_W     = 9;
	localparam int STATUS_W    = 2;

	localparam logic [CNT_W-1:0]    DEPTH_CNT        = CNT_W'(TABLE_DEPTH);
	localparam logic [GEN_BITS-1:0] GEN_ONE          = GEN_BITS'(1);
	localparam logic [LIMIT_W-1:0]  ROOT_LIMIT_RESET = LIMIT_W'(256);

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_PIN    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_UPDATE = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_UNPIN  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_VALUE  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_POP,
		S_POPGEN,
		S_CHECK,
		S_CLR_RD,
		S_CLR_WR,
		S_CLR_END,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [GEN_BITS-1:0] next_gen;
		logic                match;
	} gen_res_t;

	// per-slot metadata word: occupied mark beside the generation
	typedef struct packed {
		logic                occupied;
		logic [GEN_BITS-1:0] gen;
	} slot_meta_t;

	function automatic logic [CNT_W-1:0] to_cnt(input logic [IDX_W-1:0] i);
		return CNT_W'(i);
	endfunction

	function automatic logic [IDX_W-1:0] to_idx(input logic [CNT_W-1:0] c);
		return IDX_W'(c);
	endfunction

endpackage
`default_nettype wire

@@ sv/ght_ram.sv @@
`default_nettype none
module ght_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ sv/ght_gen_unit.sv @@
`default_nettype none
module ght_gen_unit (
	input  wire logic [ght_pkg::GEN_BITS-1:0] gen_cur,
	input  wire logic [ght_pkg::GEN_BITS-1:0] gen_ref,
	output ght_pkg::gen_res_t                 res
);

	logic [ght_pkg::GEN_BITS-1:0] inc;

	// advance the generation, skipping zero on wrap
	assign inc = gen_cur + 1'b1;

	always_comb begin
		res.next_gen = (inc == '0) ? ght_pkg::GEN_ONE : inc;
		res.match    = (gen_cur == gen_ref);
	end

endmodule
`default_nettype wire

@@ sv/generational_handle_table.sv @@
// Pin of a new slot, overflow and unknown codes go READ, RESP; update, unpin and
// value go READ, CHECK, RESP; pin from the free stack goes READ, POP, POPGEN, RESP;
// clear goes READ, a CLR_RD/CLR_WR pair per created slot, CLR_END, RESP. RESP waits
// while the previous result stalls; the next transaction is accepted back in IDLE.
// Each clear step is a registered read then a write of the slot metadata memory.
// Reset (arst_n low) empties the table, zeroes all counts and sets root_limit to 256.
`default_nettype none
`include "generational_handle_table_defines.svh"
module generational_handle_table (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [ght_pkg::FUNC_W-1:0]       func,
	input  wire logic [ght_pkg::CNT_W-1:0]        handle_slot,
	input  wire logic [ght_pkg::GEN_BITS-1:0]     handle_generation,
	input  wire logic [ght_pkg::REF_BITS-1:0]     reference_in,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [ght_pkg::STATUS_W-1:0]     status,
	output logic      [ght_pkg::CNT_W-1:0]        new_slot,
	output logic      [ght_pkg::GEN_BITS-1:0]     new_generation,
	output logic      [ght_pkg::REF_BITS-1:0]     reference_out,
	output logic      [ght_pkg::CNT_W-1:0]        live_count,
	output logic      [ght_pkg::CNT_W-1:0]        created_count,
	input  wire logic                             cfg_we,
	input  wire logic [ght_pkg::LIMIT_W-1:0]      cfg_wdata
);

	ght_pkg::state_t state_q, state_d;

	// control state
	logic [ght_pkg::CNT_W-1:0]       free_depth_q;
	logic [ght_pkg::CNT_W-1:0]       created_q;
	logic [ght_pkg::CNT_W-1:0]       live_q;
	logic [ght_pkg::LIMIT_W-1:0]     root_limit_q;
	logic                            out_valid_q;

	// captured transaction and working registers
	logic [ght_pkg::FUNC_W-1:0]   func_q;
	logic [ght_pkg::CNT_W-1:0]    hslot_q;
	logic [ght_pkg::GEN_BITS-1:0] hgen_q;
	logic [ght_pkg::REF_BITS-1:0] ref_q;
	logic [ght_pkg::IDX_W-1:0]    pop_idx_q;
	logic [ght_pkg::CNT_W-1:0]    ctr_q;
	logic [ght_pkg::STATUS_W-1:0] status_q;
	logic [ght_pkg::CNT_W-1:0]    nslot_q;
	logic [ght_pkg::GEN_BITS-1:0] ngen_q;
	logic [ght_pkg::REF_BITS-1:0] rout_q;

	// output register
	logic [ght_pkg::STATUS_W-1:0] out_status_q;
	logic [ght_pkg::CNT_W-1:0]    out_nslot_q;
	logic [ght_pkg::GEN_BITS-1:0] out_ngen_q;
	logic [ght_pkg::REF_BITS-1:0] out_rout_q;
	logic [ght_pkg::CNT_W-1:0]    out_live_q;
	logic [ght_pkg::CNT_W-1:0]    out_slots_q;

	// memory ports
	logic                         gen_we, ref_we, fs_we;
	logic [ght_pkg::IDX_W-1:0]    gen_waddr, gen_raddr, ref_waddr, fs_waddr, fs_raddr;
	ght_pkg::slot_meta_t          gen_wdata, gen_rdata;
	logic [ght_pkg::REF_BITS-1:0] ref_rdata;
	logic [ght_pkg::IDX_W-1:0]    fs_wdata, fs_rdata;

	ght_pkg::gen_res_t         gen_res;
	logic                      accept, out_free, handle_ok, can_create;
	logic [ght_pkg::IDX_W-1:0] hidx, fs_top, ctr_idx, new_idx;
	logic [ght_pkg::CNT_W-1:0] limit;
	logic [ght_pkg::CNT_W:0]   held_sum;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ght_pkg::S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign hidx    = hslot_q[ght_pkg::IDX_W-1:0] - 1'b1;
	assign fs_top  = ght_pkg::to_idx(free_depth_q - 1'b1);
	assign ctr_idx = ght_pkg::to_idx(ctr_q);
	assign new_idx = ght_pkg::to_idx(created_q);

	assign held_sum = (ght_pkg::CNT_W+1)'(live_q) + (ght_pkg::CNT_W+1)'(free_depth_q);

	// clamp the root limit to the table depth
	assign limit = (int'(root_limit_q) > ght_pkg::TABLE_DEPTH) ? ght_pkg::DEPTH_CNT
		: root_limit_q[ght_pkg::CNT_W-1:0];
	assign can_create = (created_q < limit);

	// handle names a created, occupied slot of matching generation
	assign handle_ok = (hslot_q != '0) && (hslot_q <= created_q) && gen_rdata.occupied
		&& gen_res.match;

	ght_gen_unit u_gen (
		.gen_cur (gen_rdata.gen),
		.gen_ref (hgen_q),
		.res     (gen_res)
	);

	ght_ram #(.DEPTH(ght_pkg::TABLE_DEPTH), .WIDTH($bits(ght_pkg::slot_meta_t))) u_gen_ram (
		.clk   (clk),
		.we    (gen_we),
		.waddr (gen_waddr),
		.wdata (gen_wdata),
		.raddr (gen_raddr),
		.rdata (gen_rdata)
	);

	ght_ram #(.DEPTH(ght_pkg::TABLE_DEPTH), .WIDTH(ght_pkg::REF_BITS)) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (ref_waddr),
		.wdata (ref_q),
		.raddr (hidx),
		.rdata (ref_rdata)
	);

	ght_ram #(.DEPTH(ght_pkg::TABLE_DEPTH), .WIDTH(ght_pkg::IDX_W)) u_free_ram (
		.clk   (clk),
		.we    (fs_we),
		.waddr (fs_waddr),
		.wdata (fs_wdata),
		.raddr (fs_raddr),
		.rdata (fs_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ght_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequence the operation and drive the memory ports
	always_comb begin
		state_d            = state_q;
		gen_we             = 1'b0;
		gen_waddr          = hidx;
		gen_wdata.occupied = 1'b0;
		gen_wdata.gen      = gen_res.next_gen;
		gen_raddr          = hidx;
		ref_we             = 1'b0;
		ref_waddr          = hidx;
		fs_we              = 1'b0;
		fs_waddr           = ght_pkg::to_idx(free_depth_q);
		fs_wdata           = hidx;
		fs_raddr           = fs_top;
		unique case (state_q)
			ght_pkg::S_IDLE: begin
				if (accept) begin
					state_d = ght_pkg::S_READ;
				end
			end
			ght_pkg::S_READ: begin
				unique case (func_q)
					ght_pkg::FUNC_PIN: begin
						if (free_depth_q != '0) begin
							state_d = ght_pkg::S_POP;
						end else begin
							state_d = ght_pkg::S_RESP;
							if (can_create) begin
								gen_we             = 1'b1;
								gen_waddr          = new_idx;
								gen_wdata.occupied = 1'b1;
								gen_wdata.gen      = ght_pkg::GEN_ONE;
								ref_we             = 1'b1;
								ref_waddr          = new_idx;
							end
						end
					end
					ght_pkg::FUNC_UPDATE, ght_pkg::FUNC_UNPIN, ght_pkg::FUNC_VALUE: begin
						state_d = ght_pkg::S_CHECK;
					end
					ght_pkg::FUNC_CLEAR: begin
						state_d = (created_q == '0) ? ght_pkg::S_CLR_END : ght_pkg::S_CLR_RD;
					end
					default: begin
						state_d = ght_pkg::S_RESP;
					end
				endcase
			end
			ght_pkg::S_POP: begin
				gen_raddr = fs_rdata;
				state_d   = ght_pkg::S_POPGEN;
			end
			ght_pkg::S_POPGEN: begin
				// mark the reused slot occupied, keep its generation
				gen_we             = 1'b1;
				gen_waddr          = pop_idx_q;
				gen_wdata.occupied = 1'b1;
				gen_wdata.gen      = gen_rdata.gen;
				ref_we             = 1'b1;
				ref_waddr          = pop_idx_q;
				state_d            = ght_pkg::S_RESP;
			end
			ght_pkg::S_CHECK: begin
				if (handle_ok && (func_q == ght_pkg::FUNC_UPDATE)) begin
					ref_we = 1'b1;
				end
				if (handle_ok && (func_q == ght_pkg::FUNC_UNPIN)) begin
					gen_we = 1'b1;
					fs_we  = (free_depth_q < ght_pkg::DEPTH_CNT);
				end
				state_d = ght_pkg::S_RESP;
			end
			ght_pkg::S_CLR_RD: begin
				gen_raddr = ctr_idx;
				state_d   = ght_pkg::S_CLR_WR;
			end
			ght_pkg::S_CLR_WR: begin
				gen_we    = 1'b1;
				gen_waddr = ctr_idx;
				fs_we     = 1'b1;
				fs_waddr  = ctr_idx;
				fs_wdata  = ctr_idx;
				state_d   = ((ctr_q + 1'b1) == created_q) ? ght_pkg::S_CLR_END
					: ght_pkg::S_CLR_RD;
			end
			ght_pkg::S_CLR_END: begin
				state_d = ght_pkg::S_RESP;
			end
			ght_pkg::S_RESP: begin
				if (out_free) begin
					state_d = ght_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ght_pkg::S_IDLE;
			end
		endcase
	end

	// update counters, limit and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_depth_q <= '0;
			created_q    <= '0;
			live_q       <= '0;
			root_limit_q <= ght_pkg::ROOT_LIMIT_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				root_limit_q <= cfg_wdata;
			end
			// load a new result or drop the accepted one
			if ((state_q == ght_pkg::S_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ght_pkg::S_READ: begin
					if ((func_q == ght_pkg::FUNC_PIN) && (free_depth_q == '0) && can_create) begin
						created_q <= created_q + 1'b1;
						live_q    <= live_q + 1'b1;
					end
				end
				ght_pkg::S_POP: begin
					free_depth_q <= free_depth_q - 1'b1;
				end
				ght_pkg::S_POPGEN: begin
					live_q <= live_q + 1'b1;
				end
				ght_pkg::S_CHECK: begin
					if (handle_ok && (func_q == ght_pkg::FUNC_UNPIN)) begin
						if (free_depth_q < ght_pkg::DEPTH_CNT) begin
							free_depth_q <= free_depth_q + 1'b1;
						end
						if (live_q != '0) begin
							live_q <= live_q - 1'b1;
						end
					end
				end
				ght_pkg::S_CLR_END: begin
					free_depth_q <= created_q;
					live_q       <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// capture the transaction, build the result and load the output register
	always_ff @(posedge clk) begin
		unique case (state_q)
			ght_pkg::S_IDLE: begin
				if (accept) begin
					func_q  <= func;
					hslot_q <= handle_slot;
					hgen_q  <= handle_generation;
					ref_q   <= reference_in;
				end
			end
			ght_pkg::S_READ: begin
				status_q <= ght_pkg::ST_OK;
				nslot_q  <= '0;
				ngen_q   <= '0;
				rout_q   <= '0;
				ctr_q    <= '0;
				if ((func_q == ght_pkg::FUNC_PIN) && (free_depth_q == '0)) begin
					if (can_create) begin
						nslot_q <= created_q + 1'b1;
						ngen_q  <= ght_pkg::GEN_ONE;
					end else begin
						status_q <= ght_pkg::ST_OVERFLOW;
					end
				end
			end
			ght_pkg::S_POP: begin
				pop_idx_q <= fs_rdata;
			end
			ght_pkg::S_POPGEN: begin
				nslot_q <= ght_pkg::to_cnt(pop_idx_q) + 1'b1;
				ngen_q  <= gen_rdata.gen;
			end
			ght_pkg::S_CHECK: begin
				if (!handle_ok) begin
					status_q <= ght_pkg::ST_BAD_HANDLE;
				end else if (func_q == ght_pkg::FUNC_VALUE) begin
					rout_q <= ref_rdata;
				end
			end
			ght_pkg::S_CLR_WR: begin
				ctr_q <= ctr_q + 1'b1;
			end
			ght_pkg::S_RESP: begin
				if (out_free) begin
					out_status_q <= status_q;
					out_nslot_q  <= nslot_q;
					out_ngen_q   <= ngen_q;
					out_rout_q   <= rout_q;
					out_live_q   <= live_q;
					out_slots_q  <= created_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign new_slot       = out_nslot_q;
	assign new_generation = out_ngen_q;
	assign reference_out  = out_rout_q;
	assign live_count     = out_live_q;
	assign created_count  = out_slots_q;

	`GHT_ASSERT(a_accept_busy, accept |=> in_stall, "sequencer idle after accept")
	`GHT_ASSERT(a_count_balance, !in_stall |-> (int'(held_sum) == int'(created_q)), "count imbalance")
	`GHT_NEVER(a_created_bound, created_q > ght_pkg::DEPTH_CNT, "slot count exceeds table depth")

endmodule
`default_nettype wire
